@@ hw/rtl/plla_pkg.sv @@
package plla_pkg;

    localparam int unsigned CountBits = 8;
    localparam int unsigned RateBits  = 24;
    localparam int unsigned FracBits  = 16;
    localparam int unsigned SumBits   = 40;
    localparam int unsigned LogIters  = 30;
    localparam logic [27:0] Ln2Q28    = 28'd186065280;

    // One classified term handed from the front to the back.
    typedef struct packed {
        logic [CountBits-1:0] count;
        logic [RateBits-1:0]  rate;
        logic                 included;
        logic                 last_term;
    } t_term;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_SCALE,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } t_back_state;

    // Truncated Q30 log2 fraction of a mantissa in [2^30, 2^31).
    function automatic logic [29:0] log2_frac(input logic [30:0] mant);
        logic [61:0] sq;
        logic [31:0] m;
        logic [29:0] f;
        m = {1'b0, mant};
        f = '0;
        for (int i = 29; i >= 0; i--) begin
            sq = 62'(m[30:0]) * 62'(m[30:0]);
            m  = 32'(sq >> 30);
            if (m[31]) begin
                m    = m >> 1;
                f[i] = 1'b1;
            end
        end
        return f;
    endfunction

    // Fixed-point ln(k) for an integer k > 0 with FracBits fraction bits.
    function automatic logic signed [47:0] ln_int(input int unsigned k);
        int unsigned p;
        logic [30:0] mant;
        logic [63:0] g;
        logic [95:0] prod;
        p = 0;
        for (int unsigned b = 0; b < 32; b++) begin
            if (k >= (32'd1 << b)) p = b;
        end
        mant = 31'(64'(k) << (30 - p));
        g    = (64'(p) << 30) + 64'(log2_frac(mant));
        prod = 96'(g) * 96'(Ln2Q28);
        prod = (prod + (96'd1 << (57 - FracBits))) >> (58 - FracBits);
        return 48'(prod);
    endfunction

    // ln(k!) entries, built at elaboration.
    function automatic logic [31:0] log_fact(input int unsigned k);
        logic signed [47:0] acc;
        acc = '0;
        for (int unsigned j = 2; j <= k; j++) acc = acc + ln_int(j);
        return 32'(acc);
    endfunction

endpackage

@@ hw/rtl/plla_fifo.sv @@
module plla_fifo #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> !(o_empty)) else $error("fifo drained while full without pop");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= (AW+1)'(DEPTH))) else $error("fifo count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !i_push) |=> o_empty) else $error("fifo filled from nothing");
endmodule

@@ hw/rtl/plla_back.sv @@
module plla_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  plla_pkg::t_term       i_term,
    output logic                  o_pop,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output logic [41:0]           o_res
);
    localparam int unsigned SB = plla_pkg::SumBits;
    localparam logic signed [SB-1:0] SMax = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMin = {1'b1, {(SB-1){1'b0}}};

    plla_pkg::t_back_state r_st, n_st;
    plla_pkg::t_term r_t;
    logic [31:0] r_m;           // squaring mantissa, Q1.30 with carry bit
    logic [29:0] r_frac;
    logic [4:0]  r_i;
    logic signed [5:0]  r_e;    // p - FracBits
    logic signed [35:0] r_g;    // log2 in Q30 (signed, |g| <= 2^34)
    logic signed [47:0] r_ln;
    logic signed [59:0] r_term;
    logic signed [SB-1:0] r_sum;
    logic r_dead, r_clip;
    logic [31:0] r_lf;
    logic [41:0] r_out;
    logic ovf;

    logic [31:0] rom [256];
    for (genvar k = 0; k < 256; k++) begin : g_rom
        assign rom[k] = plla_pkg::log_fact(k);
    end

    // Position of the top set bit of the rate.
    logic [4:0] top;
    always_comb begin
        top = '0;
        for (int b = 0; b < 24; b++) if (i_term.rate[b]) top = 5'(b);
    end

    logic [61:0] sq;
    logic [31:0] msq;
    assign sq  = 62'(r_m[30:0]) * 62'(r_m[30:0]);
    assign msq = 32'(sq >> 30);

    logic [63:0] mag;
    logic [87:0] mprod;
    assign mag   = r_g[35] ? 64'(-r_g) : 64'(r_g);
    assign mprod = (88'(mag) * 88'(plla_pkg::Ln2Q28) +
                    (88'd1 << (57 - plla_pkg::FracBits))) >> (58 - plla_pkg::FracBits);

    logic signed [60:0] nsum;
    assign nsum = 61'(r_sum) + 61'(r_term);

    assign o_res_valid = (r_st == plla_pkg::ST_OUT);
    assign o_res       = r_out;
    assign o_pop       = (r_st == plla_pkg::ST_IDLE) && !i_empty;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            plla_pkg::ST_IDLE:  if (!i_empty) n_st = plla_pkg::ST_LOG;
            plla_pkg::ST_LOG:   if (r_dead || r_t.rate == '0) n_st = plla_pkg::ST_ADD;
                                else if (r_i == 5'd31) n_st = plla_pkg::ST_SCALE;
            plla_pkg::ST_SCALE: n_st = plla_pkg::ST_MUL;
            plla_pkg::ST_MUL:   n_st = plla_pkg::ST_ADD;
            plla_pkg::ST_ADD:   n_st = r_t.last_term ? plla_pkg::ST_OUT : plla_pkg::ST_IDLE;
            plla_pkg::ST_OUT:   if (i_res_ready) n_st = plla_pkg::ST_IDLE;
            default:            n_st = plla_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= plla_pkg::ST_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_dead <= 1'b0;
            r_clip <= 1'b0;
        end else begin
            if (r_st == plla_pkg::ST_ADD) begin
                if (r_t.last_term) begin
                    r_sum  <= '0;
                    r_dead <= 1'b0;
                    r_clip <= 1'b0;
                end else if (!r_dead) begin
                    if (r_t.rate == '0) begin
                        if (r_t.count != '0) r_dead <= 1'b1;
                    end else begin
                        r_sum <= ovf ? (nsum[60] ? SMin : SMax) : SB'(nsum);
                        if (ovf) r_clip <= 1'b1;
                    end
                end
            end
        end
    end

    logic signed [SB-1:0] fsum;
    logic fdead, fclip;
    always_comb begin
        fsum  = r_sum;
        fdead = r_dead;
        fclip = r_clip;
        if (!r_dead) begin
            if (r_t.rate == '0) begin
                if (r_t.count != '0) fdead = 1'b1;
            end else begin
                fsum = ovf ? (nsum[60] ? SMin : SMax) : SB'(nsum);
                fclip = r_clip | ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            plla_pkg::ST_IDLE: begin
                r_t    <= i_term;
                r_i    <= '0;
                r_frac <= '0;
                r_m    <= 32'({7'd0, i_term.rate} << (5'd30 - top));
                r_e    <= 6'(top) - 6'(plla_pkg::FracBits);
                r_lf   <= rom[i_term.count];
            end
            plla_pkg::ST_LOG: begin
                if (r_i != 5'd31 && r_i < 5'd30) begin
                    r_m <= msq[31] ? (msq >> 1) : msq;
                    r_frac[5'd29 - r_i] <= msq[31];
                end
                r_i <= r_i + 1'b1;
                r_g <= (36'(r_e) << 30) + 36'(r_frac);
            end
            plla_pkg::ST_SCALE: begin
                r_ln <= r_g[35] ? -48'(mprod) : 48'(mprod);
            end
            plla_pkg::ST_MUL: begin
                r_term <= 60'(r_ln) * 60'(r_t.count) - 60'(r_t.rate) - 60'(r_lf);
            end
            plla_pkg::ST_ADD: begin
                if (!r_t.included)   r_out <= '0;
                else if (fdead)      r_out <= {1'b0, 1'b1, SMin};
                else                 r_out <= {fclip, 1'b0, fsum};
            end
            default: ;
        endcase
    end

    always_comb begin
        ovf = (nsum > 61'(SMax)) || (nsum < 61'(SMin));
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> $stable(o_res)) else $error("result moved");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res[41] && o_res[40])) else $error("flags clash");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_st == plla_pkg::ST_LOG)) else $error("pop lost");
endmodule

@@ hw/rtl/poisson_log_likelihood_accumulator.sv @@
// Poisson log-likelihood accumulator.
// Input stream: each word is one (count, rate) term; tlast marks the final
// term of a group and tuser carries the group's included flag, read on the
// last term only. For every group one output word carries the saturating
// Q24.16 sum of count*ln(rate) - rate - ln(count!), with tuser flagging an
// impossible group (zero rate, positive count) and a clipped sum.
// The front accepts words into a four-entry queue; the back works one term
// at a time. After its pop out of the queue, a term with non-zero rate
// passes through the logarithm unit (thirty squaring steps, then the
// exponent is joined to the fraction), then scale, multiply and add. A
// zero-rate term or a term of a dead group goes from the logarithm state
// straight to the add step. The result word is valid in the cycle after
// the last term's add step. While the receiver stalls, the result is held
// in its register and the queue keeps filling until full, then s_axis_tready
// drops. Synchronous active-low reset clears the queue, the group sum and
// the flags; the ln(k!) table is a constant and needs no fill.
module poisson_log_likelihood_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // count[7:0], rate[31:8]
    input  logic        s_axis_tuser,   // included
    input  logic        s_axis_tlast,   // last_term
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // log_likelihood[39:0]
    output logic [1:0]  m_axis_tuser    // impossible[0], saturated[1]
);
    plla_pkg::t_term w_in, w_head;
    logic w_full, w_empty, w_pop;
    logic [41:0] w_res;

    assign w_in = '{count: s_axis_tdata[7:0], rate: s_axis_tdata[31:8],
                    included: s_axis_tuser, last_term: s_axis_tlast};
    assign s_axis_tready = !w_full;

    plla_fifo #(.WIDTH($bits(plla_pkg::t_term)), .DEPTH(4)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(s_axis_tvalid), .i_data(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_data(w_head)
    );

    plla_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(w_empty), .i_term(w_head), .o_pop(w_pop),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = w_res[39:0];
    assign m_axis_tuser = {w_res[41], w_res[40]};
endmodule

@@ dv/testbench.sv @@
module testbench;

    localparam int SUM_W = 40;

    typedef struct {
        logic [7:0]  count;
        logic [23:0] rate;
        logic        included;
        logic        last_term;
    } term_word_t;

    typedef struct {
        logic [SUM_W-1:0] log_lik;
        logic             impossible;
        logic             saturated;
    } group_sum_t;

    // Keeps its own copy of the group state and the ln(k!) table and
    // predicts one group sum for every word that closes a group.
    class group_sum_board;
        longint     acc;
        bit         dead;
        bit         clipped;
        longint     ln_fact[256];
        group_sum_t pending[$];
        int         mismatches;
        int         matched;

        function new();
            ln_fact[0] = 0;
            for (int k = 1; k < 256; k++) ln_fact[k] = ln_fact[k-1] + fix_ln(k, 0);
            acc = 0;
            dead = 0;
            clipped = 0;
            mismatches = 0;
            matched = 0;
        endfunction

        // Natural log of x * 2^-xfrac with FracBits fraction bits.
        function longint fix_ln(int unsigned x, int xfrac);
            int p;
            longint unsigned m, frac, mag;
            longint g;
            bit neg;
            p = 0;
            frac = 0;
            for (int b = 0; b < 32; b++) if (x[b]) p = b;
            m = longint'(x) << (30 - p);
            for (int i = 29; i >= 0; i--) begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30)) begin
                    m = m >> 1;
                    frac |= 64'd1 << i;
                end
            end
            g = longint'(p - xfrac) * (64'sd1 << 30) + longint'(frac);
            neg = g < 0;
            mag = neg ? longint'(-g) : g;
            mag = mag * 64'd186065280;
            mag = (mag + (64'd1 << (57 - plla_pkg::FracBits))) >> (58 - plla_pkg::FracBits);
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function void note_term(term_word_t w);
            longint hi, lo, t;
            group_sum_t r;
            hi = (64'sd1 <<< (SUM_W - 1)) - 1;
            lo = -hi - 1;
            if (!dead) begin
                if (w.rate == 0) begin
                    if (w.count != 0) dead = 1;
                end else begin
                    t = longint'(w.count) * fix_ln(w.rate, plla_pkg::FracBits)
                        - longint'(w.rate) - ln_fact[w.count];
                    if (t > 0 && acc > hi - t) begin
                        acc = hi;
                        clipped = 1;
                    end else if (t < 0 && acc < lo - t) begin
                        acc = lo;
                        clipped = 1;
                    end else begin
                        acc += t;
                    end
                end
            end
            if (!w.last_term) return;
            if (!w.included) begin
                r.log_lik = '0;
                r.impossible = 0;
                r.saturated = 0;
            end else if (dead) begin
                r.log_lik = lo[SUM_W-1:0];
                r.impossible = 1;
                r.saturated = 0;
            end else begin
                r.log_lik = acc[SUM_W-1:0];
                r.impossible = 0;
                r.saturated = clipped;
            end
            pending.push_back(r);
            acc = 0;
            dead = 0;
            clipped = 0;
        endfunction

        function void check_sum(logic [SUM_W-1:0] data, logic [1:0] user);
            group_sum_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected group sum %h user %b", data, user);
                return;
            end
            e = pending.pop_front();
            if (data !== e.log_lik || user[0] !== e.impossible || user[1] !== e.saturated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("group sum mismatch: expected %h imp %b sat %b, got %h imp %b sat %b",
                             e.log_lik, e.impossible, e.saturated, data, user[0], user[1]);
            end else begin
                matched++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    group_sum_board board = new();
    term_word_t     terms[$];
    bit             calm = 0;
    int             groups_sent = 0;

    poisson_log_likelihood_accumulator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    task automatic add_term(logic [7:0] c, logic [23:0] r, logic inc, logic lst);
        term_word_t w;
        w.count = c;
        w.rate = r;
        w.included = inc;
        w.last_term = lst;
        terms.push_back(w);
    endtask

    function automatic logic [23:0] pick_rate();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(1, 255));
            3, 4: return 24'($urandom_range(1, 24'h00FFFF));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_word(term_word_t w);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {w.rate, w.count};
        s_axis_tuser  <= w.included;
        s_axis_tlast  <= w.last_term;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_term(w);
        if (w.last_term) groups_sent++;
        @(negedge i_clk);
    endtask

    // Receiver back-pressure in bursts; none once the run goes calm.
    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            m_axis_tready <= 1;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_sum(m_axis_tdata, m_axis_tuser);

    initial begin
        int n;
        // Directed groups: field extremes and the special cases.
        add_term(8'd0, 24'd1, 1, 1);
        add_term(8'd255, 24'hFFFFFF, 1, 1);
        add_term(8'd255, 24'd1, 1, 1);
        add_term(8'd0, 24'hFFFFFF, 1, 0);
        add_term(8'd1, 24'h010000, 1, 1);
        // Zero rate with a positive count kills the group; later terms ignored.
        add_term(8'd3, 24'h020000, 1, 0);
        add_term(8'd5, 24'd0, 1, 0);
        add_term(8'd7, 24'h030000, 1, 1);
        // Zero rate with zero count adds nothing.
        add_term(8'd0, 24'd0, 1, 0);
        add_term(8'd2, 24'h018000, 1, 1);
        add_term(8'd0, 24'd0, 1, 1);
        // Excluded groups, including an impossible one.
        add_term(8'd4, 24'h050000, 0, 1);
        add_term(8'd1, 24'd0, 1, 0);
        add_term(8'd2, 24'h001234, 0, 1);
        add_term(8'd255, 24'd0, 1, 1);
        add_term(8'hAA, 24'h555555, 1, 0);
        add_term(8'h55, 24'hAAAAAA, 1, 1);
        n = terms.size();
        while (terms.size() < n + 400) begin
            int len;
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                logic [7:0] c;
                case ($urandom_range(0, 5))
                    0: c = 8'd0;
                    1: c = 8'd255;
                    2: c = 8'($urandom_range(1, 10));
                    default: c = 8'($urandom);
                endcase
                add_term(c, pick_rate(), $urandom_range(0, 4) != 0, k == len - 1);
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        foreach (terms[i]) begin
            if (i == terms.size() - 60) calm = 1;
            send_word(terms[i]);
        end
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("%0d terms in %0d groups sent, %0d group sums matched", terms.size(),
                 groups_sent, board.matched);
        if (board.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("timeout");
        $display("tb: failure");
        $finish;
    end
endmodule
